@@ src/esc_pkg.sv @@
// ---------------------------------------------------------------------------
// esc_pkg: shared types and constants for the sensor compensation pipeline
// Holds register indexes and the calibration bundle passed between stages.
// ---------------------------------------------------------------------------
package esc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM1   = 3'd5;

    localparam int DIV_W = 32;

    // calibration words, sign or zero extended to 32 bits
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } t_calib;

    // arithmetic right shift of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        asr = 32'($signed(v) >>> n);
    endfunction

endpackage

@@ src/esc_div.sv @@
// ---------------------------------------------------------------------------
// esc_div: pipelined unsigned restoring divider
// One quotient bit per stage; a new division may enter every cycle.
// ---------------------------------------------------------------------------
module esc_div #(
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [31:0]      i_num,
    input  logic [31:0]      i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [31:0]      o_quo,
    output logic [TAG_W-1:0] o_tag
);
    import esc_pkg::*;

    logic [DIV_W:0]     r_vld;
    logic [31:0]        r_rem [DIV_W+1];
    logic [31:0]        r_quo [DIV_W+1];
    logic [31:0]        r_den [DIV_W+1];
    logic [TAG_W-1:0]   r_tag [DIV_W+1];

    assign r_vld[0] = i_valid;
    assign r_rem[0] = '0;
    assign r_quo[0] = i_num;
    assign r_den[0] = i_den;
    assign r_tag[0] = i_tag;

    // one shift-subtract step per stage
    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [32:0] n_trial;
        logic [32:0] n_sh;
        always_comb begin
            n_sh    = {r_rem[k], r_quo[k][31]};
            n_trial = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_den[k+1] <= r_den[k];
            r_tag[k+1] <= r_tag[k];
            if (!n_trial[32]) begin
                r_rem[k+1] <= n_trial[31:0];
                r_quo[k+1] <= {r_quo[k][30:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_sh[31:0];
                r_quo[k+1] <= {r_quo[k][30:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[DIV_W];
    assign o_quo   = r_quo[DIV_W];
    assign o_tag   = r_tag[DIV_W];

endmodule

@@ src/esc_front.sv @@
// ---------------------------------------------------------------------------
// esc_front: fine temperature, pressure divisor setup and humidity path
// Nine register stages, one multiply level each.
// ---------------------------------------------------------------------------
module esc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [19:0]          i_at,
    input  logic [19:0]          i_ap,
    input  logic [15:0]          i_ah,
    input  esc_pkg::t_calib      i_cal,
    output logic                 o_valid,
    output logic [31:0]          o_temp,
    output logic [31:0]          o_num,
    output logic [31:0]          o_den,
    output logic                 o_big,
    output logic [16:0]          o_hum
);
    import esc_pkg::*;

    localparam int NS = 7;
    logic [NS-1:0] r_v;
    logic [31:0] r_ah1, r_ap1;
    // stage 1
    logic [31:0] r1_a, r1_dd, r1_at;
    // stage 2
    logic [31:0] r2_fine, r2_ah;
    // stage 3
    logic [31:0] r3_temp, r3_pa, r3_q, r3_ha, r3_ah, r3_ap;
    // stage 4
    logic [31:0] r4_b6, r4_b5, r4_a3, r4_a2, r4_hb, r4_d1, r4_d3, r4_temp, r4_ap;
    // stage 5
    logic [31:0] r5_b, r5_a, r5_hb, r5_d, r5_temp, r5_ap;
    // stage 6
    logic [31:0] r6_b, r6_den, r6_hb, r6_d, r6_temp;
    // stage 7
    logic [31:0] r7_num, r7_den, r7_ha, r7_temp;
    logic        r7_big;
    logic [16:0] r_hum;

    logic [31:0] n_d0, n_fine, n_pa, n_ha, n_hdd, n_p, n_hx;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_comb begin
        n_d0   = 32'(i_at >> 4) - i_cal.t1;
        n_fine = r1_a + asr(asr(r1_dd, 12) * i_cal.t3, 14);
        n_pa   = asr(r2_fine, 1) - 32'd64000;
        n_ha   = r2_fine - 32'd76800;
        n_hdd  = asr(asr(r4_d1, 10) * (asr(r4_d3, 11) + 32'd32768), 10) + 32'd2097152;
        n_p    = ((32'd1048576 - r5_ap) - asr(r5_b, 12)) * 32'd3125;
        n_hx   = r6_hb * r6_d;
    end

    always_ff @(posedge i_clk) begin
        // stage 1: temperature products
        r1_a  <= asr((32'(i_at >> 3) - (i_cal.t1 << 1)) * i_cal.t2, 11);
        r1_dd <= n_d0 * n_d0;
        r_ap1 <= 32'(i_ap);
        r_ah1 <= 32'(i_ah);
        // stage 2: fine temperature
        r2_fine <= n_fine;
        r1_at   <= r_ap1;
        r2_ah   <= r_ah1;
        // stage 3: temperature, pressure and humidity operands
        r3_temp <= asr(r2_fine * 32'd5 + 32'd128, 8);
        r3_pa   <= n_pa;
        r3_q    <= asr(n_pa, 2) * asr(n_pa, 2);
        r3_ha   <= n_ha;
        r3_ah   <= r2_ah;
        r3_ap   <= r1_at;
        // stage 4
        r4_b6   <= asr(r3_q, 11) * i_cal.p6;
        r4_b5   <= (r3_pa * i_cal.p5) << 1;
        r4_a3   <= asr(i_cal.p3 * asr(r3_q, 13), 3);
        r4_a2   <= asr(i_cal.p2 * r3_pa, 1);
        r4_hb   <= asr(((r3_ah << 14) - (i_cal.h4 << 20) - (i_cal.h5 * r3_ha))
                       + 32'd16384, 15);
        r4_d1   <= r3_ha * i_cal.h6;
        r4_d3   <= r3_ha * i_cal.h3;
        r4_temp <= r3_temp;
        r4_ap   <= r3_ap;
        // stage 5
        r5_b    <= asr(r4_b6 + r4_b5, 2) + (i_cal.p4 << 16);
        r5_a    <= asr(r4_a3 + r4_a2, 18) + 32'd32768;
        r5_hb   <= r4_hb;
        r5_d    <= n_hdd;
        r5_temp <= r4_temp;
        r5_ap   <= r4_ap;
        // stage 6
        r6_b    <= n_p;
        r6_den  <= asr(r5_a * i_cal.p1, 15);
        r6_hb   <= r5_hb;
        r6_d    <= asr(r5_d * i_cal.h2 + 32'd8192, 14);
        r6_temp <= r5_temp;
        // stage 7: divider operands and humidity product
        r7_big  <= r6_b[31];
        r7_num  <= r6_b[31] ? r6_b : (r6_b << 1);
        r7_den  <= r6_den;
        r7_ha   <= n_hx;
        r7_temp <= r6_temp;
    end

    // stage 8: humidity square term
    logic        r_v8;
    logic [31:0] r8_num, r8_den, r8_temp, r8_ha, r8_sq;
    logic        r8_big;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= r_v[NS-1];
        end
        r8_ha   <= r7_ha;
        r8_sq   <= asr(r7_ha, 15) * asr(r7_ha, 15);
        r8_num  <= r7_num;
        r8_den  <= r7_den;
        r8_big  <= r7_big;
        r8_temp <= r7_temp;
    end

    // humidity correction and clamp
    logic [31:0] n_s, n_hf;
    always_comb begin
        n_s  = asr(asr(r8_sq, 7) * i_cal.h1, 4);
        n_hf = r8_ha - n_s;
        if (n_hf[31]) begin
            n_hf = '0;
        end else if (n_hf > 32'd419430400) begin
            n_hf = 32'd419430400;
        end
    end

    // stage 9: outputs aligned
    logic        r_v9;
    logic [31:0] r9_num, r9_den, r9_temp;
    logic        r9_big;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= r_v8;
        end
        r_hum   <= n_hf[28:12];
        r9_num  <= r8_num;
        r9_den  <= r8_den;
        r9_big  <= r8_big;
        r9_temp <= r8_temp;
    end

    assign o_valid = r_v9;
    assign o_temp  = r9_temp;
    assign o_num   = r9_num;
    assign o_den   = r9_den;
    assign o_big   = r9_big;
    assign o_hum   = r_hum;

endmodule

@@ src/esc_back.sv @@
// ---------------------------------------------------------------------------
// esc_back: pressure correction after the division
// Three register stages: first products, second products, then the final sum.
// ---------------------------------------------------------------------------
module esc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_quo,
    input  logic            i_big,
    input  logic            i_dz,
    input  logic [31:0]     i_temp,
    input  logic [16:0]     i_hum,
    input  esc_pkg::t_calib i_cal,
    output logic            o_valid,
    output logic [31:0]     o_temp,
    output logic [31:0]     o_pres,
    output logic [16:0]     o_hum,
    output logic            o_dz
);
    import esc_pkg::*;

    logic [31:0] n_p, r_p, r_p2, r_sq, r_a, r_b, r_b2, r_pres;
    logic [31:0] r_temp, r_temp2, r_temp3;
    logic [16:0] r_hum, r_hum2, r_hum3;
    logic        r_dz, r_dz2, r_dz3, r_v1, r_v2, r_v3;

    assign n_p = i_big ? (i_quo << 1) : i_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // first correction products
        r_p    <= n_p;
        r_sq   <= (n_p >> 3) * (n_p >> 3);
        r_b    <= asr((n_p >> 2) * i_cal.p8, 13);
        r_temp <= i_temp;
        r_hum  <= i_hum;
        r_dz   <= i_dz;
        // square term scaled by P9
        r_p2    <= r_p;
        r_a     <= asr(i_cal.p9 * (r_sq >> 13), 12);
        r_b2    <= r_b;
        r_temp2 <= r_temp;
        r_hum2  <= r_hum;
        r_dz2   <= r_dz;
        // final pressure
        r_pres  <= r_dz2 ? '0 : r_p2 + asr(r_a + r_b2 + i_cal.p7, 4);
        r_temp3 <= r_temp2;
        r_hum3  <= r_hum2;
        r_dz3   <= r_dz2;
    end

    assign o_valid = r_v3;
    assign o_temp  = r_temp3;
    assign o_pres  = r_pres;
    assign o_hum   = r_hum3;
    assign o_dz    = r_dz3;

endmodule

@@ src/env_sensor_compensation_unit.sv @@
// ---------------------------------------------------------------------------
// env_sensor_compensation_unit: integer compensation of sensor readings
// Fine temperature, pressure and humidity, fully pipelined.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  input   | i_start / o_busy       | i_adc_temperature, i_adc_pressure, i_adc_humidity
//  config  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//  result  | o_done strobe          | o_temperature_centi, o_pressure_pa, ...
//
// One request per cycle; each result passes 9 front stages, 32 divider stages
// (one quotient bit each), 3 back stages and the output register.
// o_busy is always low; the receiver cannot stall, so no stalls exist.
// Synchronous active-low reset clears the valid chain and the configuration registers.
module env_sensor_compensation_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [19:0]               i_adc_temperature,
    input  logic [19:0]               i_adc_pressure,
    input  logic [15:0]               i_adc_humidity,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [esc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [esc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_done,
    output logic signed [31:0]        o_temperature_centi,
    output logic [31:0]               o_pressure_pa,
    output logic [16:0]               o_humidity_q10,
    output logic                      o_pressure_divisor_zero
);
    import esc_pkg::*;

    localparam int TAG_W = 32 + 17 + 1 + 1;

    logic [47:0] r_tc, r_p0, r_p1, r_p2;
    logic [31:0] r_h0, r_h1;
    t_calib      w_cal;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0; r_p0 <= '0; r_p1 <= '0; r_p2 <= '0; r_h0 <= '0; r_h1 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP:   r_tc <= i_cfg_data;
                REG_PRESS0: r_p0 <= i_cfg_data;
                REG_PRESS1: r_p1 <= i_cfg_data;
                REG_PRESS2: r_p2 <= i_cfg_data;
                REG_HUM0:   r_h0 <= i_cfg_data[31:0];
                REG_HUM1:   r_h1 <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // field extraction
    always_comb begin
        w_cal.t1 = {16'd0, r_tc[15:0]};
        w_cal.t2 = 32'($signed(r_tc[31:16]));
        w_cal.t3 = 32'($signed(r_tc[47:32]));
        w_cal.p1 = {16'd0, r_p0[15:0]};
        w_cal.p2 = 32'($signed(r_p0[31:16]));
        w_cal.p3 = 32'($signed(r_p0[47:32]));
        w_cal.p4 = 32'($signed(r_p1[15:0]));
        w_cal.p5 = 32'($signed(r_p1[31:16]));
        w_cal.p6 = 32'($signed(r_p1[47:32]));
        w_cal.p7 = 32'($signed(r_p2[15:0]));
        w_cal.p8 = 32'($signed(r_p2[31:16]));
        w_cal.p9 = 32'($signed(r_p2[47:32]));
        w_cal.h1 = {24'd0, r_h0[7:0]};
        w_cal.h2 = 32'($signed(r_h0[23:8]));
        w_cal.h3 = {24'd0, r_h0[31:24]};
        w_cal.h4 = 32'($signed(r_h1[11:0]));
        w_cal.h5 = 32'($signed(r_h1[23:12]));
        w_cal.h6 = 32'($signed(r_h1[31:24]));
    end

    logic        f_v, f_big;
    logic [31:0] f_temp, f_num, f_den;
    logic [16:0] f_hum;

    esc_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_start),
        .i_at(i_adc_temperature), .i_ap(i_adc_pressure), .i_ah(i_adc_humidity),
        .i_cal(w_cal), .o_valid(f_v), .o_temp(f_temp), .o_num(f_num),
        .o_den(f_den), .o_big(f_big), .o_hum(f_hum)
    );

    logic             d_v;
    logic [31:0]      d_quo;
    logic [TAG_W-1:0] d_tag;
    logic             w_dz;
    assign w_dz = (f_den == '0);

    esc_div #(.TAG_W(TAG_W)) u_div (
        .i_clk, .i_rst_n, .i_valid(f_v), .i_num(f_num),
        .i_den(w_dz ? 32'd1 : f_den), .i_tag({f_temp, f_hum, f_big, w_dz}),
        .o_valid(d_v), .o_quo(d_quo), .o_tag(d_tag)
    );

    logic        b_v, b_dz;
    logic [31:0] b_temp, b_pres;
    logic [16:0] b_hum;

    esc_back u_back (
        .i_clk, .i_rst_n, .i_valid(d_v), .i_quo(d_quo), .i_big(d_tag[1]),
        .i_dz(d_tag[0]), .i_temp(d_tag[TAG_W-1 -: 32]), .i_hum(d_tag[18:2]),
        .i_cal(w_cal), .o_valid(b_v), .o_temp(b_temp), .o_pres(b_pres),
        .o_hum(b_hum), .o_dz(b_dz)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= b_v;
        end
        o_temperature_centi     <= $signed(b_temp);
        o_pressure_pa           <= b_pres;
        o_humidity_q10          <= b_hum;
        o_pressure_divisor_zero <= b_dz;
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_humidity_q10 <= 17'd102400) else $error("humidity out of range");
    a_dz_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_pressure_divisor_zero |-> o_pressure_pa == '0) else $error("dz pres");
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_v |=> o_done) else $error("done lost");
`endif

endmodule
